// File: src/gdrd_pkg.sv
// shared types, constants and helpers of the genotype dosage record decoder
`timescale 1ns / 1ps
`default_nettype none
package gdrd_pkg;

   localparam int MAX_SUBJECTS = 4096;
   localparam int WORD_W       = 16;
   localparam int IDX_W        = 12;
   localparam int CNT_W        = 13;
   localparam int DOSAGE_W     = 18;
   localparam int PROB0_W      = 18;
   localparam int PROB_W       = 17;
   localparam int CALC_W       = 19;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FORMAT_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUBJECT_COUNT = 2'd1;

   // record formats
   localparam logic [1:0] MODE_DOSAGE  = 2'd0;
   localparam logic [1:0] MODE_PAIR    = 2'd1;
   localparam logic [1:0] MODE_FLAGGED = 2'd2;
   localparam logic [1:0] MODE_SPARE   = 2'd3;

   localparam logic [WORD_W-1:0] MISSING_WORD = 16'hFFFF;
   localparam logic [14:0]       FLAGGED_UNIT = 15'd10000;

   localparam logic signed [CALC_W-1:0] PAIR_DENOM     = 19'sd65535;
   localparam logic signed [CALC_W-1:0] FLAGGED_DENOM  = 19'sd20000;
   localparam logic signed [CALC_W-1:0] FLAGGED_TWICE  = 19'sd40000;
   localparam logic signed [CALC_W-1:0] PROB_SATURATE  = 19'sd65535;

   typedef enum logic {
      PHASE_ARRAY,
      PHASE_EXTRA
   } phase_type;

   typedef enum logic [2:0] {
      OP_DOSAGE,
      OP_PAIR,
      OP_DIRECT,
      OP_QUEUE_WRITE,
      OP_EXTRA_SHORT,
      OP_EXTRA_LONG
   } op_kind_type;

   typedef struct packed {
      op_kind_type        kind;
      logic               done;
      logic [IDX_W-1:0]   slot;
      logic [IDX_W-1:0]   subject;
      logic [WORD_W-1:0]  word_a;
      logic [WORD_W-1:0]  word_b;
      logic [WORD_W-1:0]  word_c;
   } op_type;

   typedef struct packed {
      logic [IDX_W-1:0] subject;
      logic [14:0]      dosage;
   } entry_type;

   function automatic logic signed [CALC_W-1:0] widen(input logic [WORD_W-1:0] v);
      return signed'({3'b000, v});
   endfunction

endpackage
`default_nettype wire

// File: src/gdrd_if.sv
// channel interfaces: stream words in, results out, register writes
`timescale 1ns / 1ps
`default_nettype none
interface gdrd_req_if import gdrd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] data_word;
   modport source (output valid, output data_word, input ready);
   modport sink   (input valid, input data_word, output ready);
endinterface

interface gdrd_rsp_if import gdrd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [IDX_W-1:0]           subject_index;
   logic [DOSAGE_W-1:0]        dosage_value;
   logic signed [PROB0_W-1:0]  prob_zero;
   logic signed [PROB_W-1:0]   prob_one;
   logic signed [PROB_W-1:0]   prob_two;
   logic                       is_missing;
   logic                       record_done;
   modport source (output valid, output subject_index, output dosage_value,
                   output prob_zero, output prob_one, output prob_two,
                   output is_missing, output record_done, input ready);
   modport sink   (input valid, input subject_index, input dosage_value,
                   input prob_zero, input prob_one, input prob_two,
                   input is_missing, input record_done, output ready);
endinterface

interface gdrd_csr_if import gdrd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: src/gdrd_front.sv
// front end: takes stream words, tracks record framing and queue pointers, issues ops
`timescale 1ns / 1ps
`default_nettype none
module gdrd_front import gdrd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   gdrd_req_if.sink    req_bus,
   gdrd_csr_if.sink    csr_bus,
   output logic        push_valid,
   output op_type      push_op,
   input  wire logic   push_ready
);

   logic [1:0]       fmt_ff, fmt_in;
   logic [CNT_W-1:0] count_ff, count_in;
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] tail_ff, tail_in;
   logic [1:0]       wis_ff, wis_in;
   logic [WORD_W-1:0] held1_ff, held1_in;
   logic [WORD_W-1:0] held2_ff, held2_in;

   logic              accept;
   logic              csr_write;
   logic [WORD_W-1:0] w;
   logic [1:0]        mode;
   logic [CNT_W-1:0]  count_eff;
   logic [CNT_W-1:0]  cnt_next;
   logic [CNT_W-1:0]  head_next;
   logic              last;
   logic              head_last;
   logic              queue_empty;
   logic              tail_room;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = push_ready && !csr_write;
   assign csr_write     = csr_bus.valid;
   assign accept        = req_bus.valid && push_ready && !csr_write;
   assign w             = req_bus.data_word;
   assign mode          = (fmt_ff == MODE_SPARE) ? MODE_FLAGGED : fmt_ff;
   assign count_eff     = (count_ff == '0) ? CNT_W'(1) :
                          (count_ff > CNT_W'(MAX_SUBJECTS)) ? CNT_W'(MAX_SUBJECTS) : count_ff;
   assign cnt_next      = cnt_ff + CNT_W'(1);
   assign last          = cnt_next >= count_eff;
   assign head_next     = head_ff + CNT_W'(1);
   assign head_last     = head_next >= tail_ff;
   assign queue_empty   = (head_ff >= tail_ff) || (head_ff >= CNT_W'(MAX_SUBJECTS));
   assign tail_room     = tail_ff < CNT_W'(MAX_SUBJECTS);

   // next state
   always_comb begin
      fmt_in   = fmt_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      wis_in   = wis_ff;
      held1_in = held1_ff;
      held2_in = held2_ff;
      if (csr_write) begin
         if (csr_bus.index == CSR_FORMAT_MODE || csr_bus.index == CSR_SUBJECT_COUNT) begin
            if (csr_bus.index == CSR_FORMAT_MODE) begin
               fmt_in = csr_bus.data[1:0];
            end else begin
               count_in = csr_bus.data;
            end
            phase_in = PHASE_ARRAY;
            cnt_in   = '0;
            head_in  = '0;
            tail_in  = '0;
            wis_in   = '0;
         end
      end else if (accept) begin
         unique case (mode)
            MODE_DOSAGE: begin
               cnt_in = last ? '0 : cnt_next;
            end
            MODE_PAIR: begin
               if (wis_ff == 2'd0) begin
                  held1_in = w;
                  wis_in   = 2'd1;
               end else begin
                  wis_in = 2'd0;
                  cnt_in = last ? '0 : cnt_next;
               end
            end
            default: begin
               if (phase_ff == PHASE_ARRAY) begin
                  cnt_in = last ? '0 : cnt_next;
                  if (w[15]) begin
                     if (tail_room) begin
                        tail_in = tail_ff + CNT_W'(1);
                     end
                     if (last) begin
                        phase_in = PHASE_EXTRA;
                        wis_in   = 2'd0;
                     end
                  end else if (last) begin
                     if (tail_ff > head_ff) begin
                        phase_in = PHASE_EXTRA;
                        wis_in   = 2'd0;
                     end else begin
                        phase_in = PHASE_ARRAY;
                        head_in  = '0;
                        tail_in  = '0;
                        wis_in   = '0;
                     end
                  end
               end else if (queue_empty) begin
                  phase_in = PHASE_ARRAY;
                  cnt_in   = '0;
                  head_in  = '0;
                  tail_in  = '0;
                  wis_in   = '0;
               end else begin
                  priority if (wis_ff == 2'd0 && w[15]) begin
                     held1_in = {1'b0, w[14:0]};
                     wis_in   = 2'd1;
                  end else if (wis_ff == 2'd1) begin
                     held2_in = w;
                     wis_in   = 2'd2;
                  end else begin
                     wis_in  = 2'd0;
                     head_in = head_next;
                     if (head_last) begin
                        phase_in = PHASE_ARRAY;
                        cnt_in   = '0;
                        head_in  = '0;
                        tail_in  = '0;
                     end
                  end
               end
            end
         endcase
      end
   end

   // ops towards the back end
   always_comb begin
      push_valid     = 1'b0;
      push_op        = '0;
      push_op.kind   = OP_DOSAGE;
      push_op.subject = cnt_ff[IDX_W-1:0];
      push_op.slot   = head_ff[IDX_W-1:0];
      push_op.done   = last;
      push_op.word_a = w;
      if (accept) begin
         unique case (mode)
            MODE_DOSAGE: begin
               push_valid = 1'b1;
            end
            MODE_PAIR: begin
               push_valid     = wis_ff != 2'd0;
               push_op.kind   = OP_PAIR;
               push_op.word_a = held1_ff;
               push_op.word_b = w;
            end
            default: begin
               if (phase_ff == PHASE_ARRAY) begin
                  if (w[15]) begin
                     push_valid   = tail_room;
                     push_op.kind = OP_QUEUE_WRITE;
                     push_op.slot = tail_ff[IDX_W-1:0];
                  end else begin
                     push_valid   = 1'b1;
                     push_op.kind = OP_DIRECT;
                     push_op.done = last && !(tail_ff > head_ff);
                  end
               end else if (!queue_empty) begin
                  push_op.done = head_last;
                  priority if (wis_ff == 2'd0 && w[15]) begin
                     push_valid = 1'b0;
                  end else if (wis_ff == 2'd0) begin
                     push_valid   = 1'b1;
                     push_op.kind = OP_EXTRA_SHORT;
                  end else if (wis_ff == 2'd1) begin
                     push_valid = 1'b0;
                  end else begin
                     push_valid     = 1'b1;
                     push_op.kind   = OP_EXTRA_LONG;
                     push_op.word_a = held1_ff;
                     push_op.word_b = held2_ff;
                     push_op.word_c = w;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= MODE_FLAGGED;
         count_ff <= CNT_W'(1);
         phase_ff <= PHASE_ARRAY;
         cnt_ff   <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         wis_ff   <= '0;
         held1_ff <= '0;
         held2_ff <= '0;
      end else begin
         fmt_ff   <= fmt_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         wis_ff   <= wis_in;
         held1_ff <= held1_in;
         held2_ff <= held2_in;
      end
   end

endmodule
`default_nettype wire

// File: src/gdrd_fifo.sv
// short op queue between front and back ends
`timescale 1ns / 1ps
`default_nettype none
module gdrd_fifo import gdrd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire op_type  push_op,
   output logic         push_ready,
   output logic         pop_valid,
   output op_type       pop_op,
   input  wire logic    pop
);

   op_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]   fill_ff, fill_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = fill_ff != (FIFO_PTR_W+1)'(FIFO_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (FIFO_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (FIFO_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

// File: src/gdrd_back.sv
// back end: flagged-subject memory, value arithmetic and result register
`timescale 1ns / 1ps
`default_nettype none
module gdrd_back import gdrd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    op_valid,
   input  wire op_type  op,
   output logic         op_pop,
   gdrd_rsp_if.source   rsp_bus
);

   logic [$bits(entry_type)-1:0] queue_mem [MAX_SUBJECTS];
   entry_type rd_ff;
   op_type    a_op_ff, a_op_in;
   logic      a_valid_ff, a_valid_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]           idx_ff;
   logic [DOSAGE_W-1:0]        dos_ff;
   logic signed [PROB0_W-1:0]  p0_ff;
   logic signed [PROB_W-1:0]   p1_ff;
   logic signed [PROB_W-1:0]   p2_ff;
   logic                       miss_ff;
   logic                       done_ff;

   logic is_write;
   logic is_read;
   logic rsp_load;
   logic a_free;

   logic [IDX_W-1:0]           idx_c;
   logic signed [CALC_W-1:0]   dos_c, p0_c, p1_c, p2_c;
   logic                       miss_c;
   logic signed [CALC_W-1:0]   d_dir, d_ent, ea, eb, ec;
   logic                       a_missing, b_missing;

   assign is_write = op.kind == OP_QUEUE_WRITE;
   assign is_read  = op.kind == OP_EXTRA_SHORT || op.kind == OP_EXTRA_LONG;
   assign rsp_load = a_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign a_free   = !a_valid_ff || rsp_load;
   assign op_pop   = op_valid && (is_write || a_free);

   always_ff @(posedge clock) begin
      if (op_pop && is_write) begin
         queue_mem[op.slot] <= {op.subject, op.word_a[14:0]};
      end
      if (op_pop && is_read) begin
         rd_ff <= entry_type'(queue_mem[op.slot]);
      end
   end

   always_comb begin
      a_op_in    = a_op_ff;
      a_valid_in = a_valid_ff;
      if (op_pop && !is_write) begin
         a_op_in    = op;
         a_valid_in = 1'b1;
      end else if (rsp_load) begin
         a_valid_in = 1'b0;
      end
   end

   // value arithmetic
   assign d_dir     = widen({1'b0, a_op_ff.word_a[14:0]});
   assign d_ent     = widen({1'b0, rd_ff.dosage});
   assign ea        = widen(a_op_ff.word_a);
   assign eb        = widen(a_op_ff.word_b);
   assign ec        = widen(a_op_ff.word_c);
   assign a_missing = a_op_ff.word_a == MISSING_WORD;
   assign b_missing = a_op_ff.word_b == MISSING_WORD;

   always_comb begin
      idx_c  = a_op_ff.subject;
      dos_c  = '0;
      p0_c   = '0;
      p1_c   = '0;
      p2_c   = '0;
      miss_c = 1'b0;
      unique case (a_op_ff.kind)
         OP_DOSAGE: begin
            miss_c = a_missing;
            dos_c  = a_missing ? '0 : ea;
         end
         OP_PAIR: begin
            miss_c = a_missing || b_missing;
            if (a_missing || b_missing) begin
               p1_c = a_missing ? '0 : ea;
               p2_c = b_missing ? '0 : eb;
            end else begin
               dos_c = ea + (eb <<< 1);
               p0_c  = PAIR_DENOM - ea - eb;
               p1_c  = ea;
               p2_c  = eb;
            end
         end
         OP_DIRECT: begin
            dos_c = d_dir <<< 1;
            if (a_op_ff.word_a[14:0] < FLAGGED_UNIT) begin
               p0_c = FLAGGED_DENOM - (d_dir <<< 1);
               p1_c = d_dir <<< 1;
            end else begin
               p1_c = FLAGGED_TWICE - (d_dir <<< 1);
               p2_c = (d_dir <<< 1) - FLAGGED_DENOM;
            end
         end
         OP_EXTRA_SHORT: begin
            idx_c = rd_ff.subject;
            dos_c = d_ent <<< 1;
            p0_c  = FLAGGED_DENOM - ea - d_ent;
            p1_c  = ea <<< 1;
            p2_c  = d_ent - ea;
         end
         OP_EXTRA_LONG: begin
            idx_c = rd_ff.subject;
            dos_c = d_ent <<< 1;
            p0_c  = eb <<< 1;
            p1_c  = ea <<< 1;
            // oversized p2 saturates
            p2_c  = a_op_ff.word_c[15] ? PROB_SATURATE : (ec <<< 1);
         end
         default: begin
            idx_c = a_op_ff.subject;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         idx_ff  <= idx_c;
         dos_ff  <= dos_c[DOSAGE_W-1:0];
         p0_ff   <= p0_c[PROB0_W-1:0];
         p1_ff   <= p1_c[PROB_W-1:0];
         p2_ff   <= p2_c[PROB_W-1:0];
         miss_ff <= miss_c;
         done_ff <= a_op_ff.done;
      end
      a_op_ff <= a_op_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.subject_index = idx_ff;
   assign rsp_bus.dosage_value  = dos_ff;
   assign rsp_bus.prob_zero     = p0_ff;
   assign rsp_bus.prob_one      = p1_ff;
   assign rsp_bus.prob_two      = p2_ff;
   assign rsp_bus.is_missing    = miss_ff;
   assign rsp_bus.record_done   = done_ff;

endmodule
`default_nettype wire

// File: src/genotype_dosage_record_decoder.sv
// top level of the genotype dosage record decoder
//
// Takes one 16-bit record word per cycle and gives one result word per cycle
// at most; words that only carry part of a subject give no result. The front
// end accepts a word in a cycle whenever its four-entry op queue has room
// and no register write is offered in that cycle;
// a result reaches rsp_bus through the queue, the flagged-subject memory
// read stage and the result register. The flagged subjects live in a
// 4096 x 27 single-port memory in the back end, written in the dosage array
// phase and read back in order during the extras phase; no clearing pass is
// run after reset. Register writes are always ready; writes to the format or
// subject-count register restart the current record.
`timescale 1ns / 1ps
`default_nettype none
module genotype_dosage_record_decoder import gdrd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   gdrd_req_if.sink    req_bus,
   gdrd_rsp_if.source  rsp_bus,
   gdrd_csr_if.sink    csr_bus
);

   logic   push_valid;
   op_type push_op;
   logic   push_ready;
   logic   pop_valid;
   op_type pop_op;
   logic   pop;

   gdrd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready)
   );

   gdrd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_op     (pop_op),
      .pop        (pop)
   );

   gdrd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (pop_valid),
      .op       (pop_op),
      .op_pop   (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule
`default_nettype wire

// File: src/gdrd_checker.sv
// port-level checks of the decoder and their binding
`timescale 1ns / 1ps
`default_nettype none
module gdrd_checker import gdrd_pkg::*; (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [IDX_W-1:0]          rsp_subject_index,
   input wire logic [DOSAGE_W-1:0]       rsp_dosage_value,
   input wire logic signed [PROB0_W-1:0] rsp_prob_zero,
   input wire logic                      rsp_is_missing,
   input wire logic                      rsp_record_done
);

   // no result word right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // a missing subject carries zero dosage and zero p0
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_missing |-> rsp_dosage_value == '0 && rsp_prob_zero == '0)
      else $error("missing subject with non-zero dosage or p0");

   // stalled result word stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_subject_index) && $stable(rsp_record_done))
      else $error("result word changed while stalled");

endmodule

bind genotype_dosage_record_decoder gdrd_checker u_gdrd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_subject_index (rsp_bus.subject_index),
   .rsp_dosage_value  (rsp_bus.dosage_value),
   .rsp_prob_zero     (rsp_bus.prob_zero),
   .rsp_is_missing    (rsp_bus.is_missing),
   .rsp_record_done   (rsp_bus.record_done)
);
`default_nettype wire
